// ----- rtl/tct_pkg.sv -----
`timescale 1ns / 1ps
// tct_pkg: shared types, tables and helper functions for the six-tetrahedron cube triangulator
// no dependencies; used by the interfaces, tct_emitter and tetra_cube_triangulator
package tct_pkg;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DIV_W     = 7;
  localparam int unsigned ID_W      = 23;
  localparam int unsigned EDGE_W    = 5;
  localparam int unsigned NUM_EDGES = 19;
  localparam int unsigned NUM_TETRA = 6;
  localparam int unsigned NTRI      = 2 * NUM_TETRA;
  localparam int unsigned SEL_W     = $clog2(NTRI);
  localparam int unsigned ZY_W      = COORD_W + DIV_W;
  localparam int unsigned IDX_W     = ZY_W + DIV_W;

  localparam logic [DIV_W-1:0] RESET_DIV = 7'd64;

  // triangle count of a tetrahedron
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_TWO  = 2'd2;

  localparam logic [2:0] EDGE_ENDS [NUM_EDGES][2] = '{
    '{3'd0, 3'd1}, '{3'd1, 3'd3}, '{3'd2, 3'd3}, '{3'd0, 3'd2},
    '{3'd4, 3'd5}, '{3'd5, 3'd7}, '{3'd6, 3'd7}, '{3'd4, 3'd6},
    '{3'd0, 3'd4}, '{3'd1, 3'd5}, '{3'd2, 3'd6}, '{3'd3, 3'd7},
    '{3'd0, 3'd3}, '{3'd0, 3'd6}, '{3'd0, 3'd5},
    '{3'd4, 3'd7}, '{3'd1, 3'd7}, '{3'd2, 3'd7},
    '{3'd0, 3'd7}
  };

  localparam logic [2:0] TETRA [NUM_TETRA][4] = '{
    '{3'd0, 3'd1, 3'd5, 3'd7}, '{3'd0, 3'd5, 3'd4, 3'd7}, '{3'd0, 3'd4, 3'd6, 3'd7},
    '{3'd0, 3'd6, 3'd2, 3'd7}, '{3'd0, 3'd2, 3'd3, 3'd7}, '{3'd0, 3'd3, 3'd1, 3'd7}
  };

  localparam logic [1:0] MASK_PERM [16][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd3, 2'd0, 2'd2, 2'd1},
    '{2'd1, 2'd3, 2'd2, 2'd0}, '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd0, 2'd1, 2'd2, 2'd3}
  };

  localparam logic [1:0] MASK_KIND [16] = '{
    KIND_NONE, KIND_ONE, KIND_ONE, KIND_TWO, KIND_ONE, KIND_TWO, KIND_TWO, KIND_ONE,
    KIND_ONE, KIND_TWO, KIND_TWO, KIND_ONE, KIND_TWO, KIND_ONE, KIND_ONE, KIND_NONE
  };

  typedef struct packed {
    logic [EDGE_W-1:0] a;
    logic [EDGE_W-1:0] b;
    logic [EDGE_W-1:0] c;
  } tri_edges_t;

  // two slots per tetrahedron, slot order is output order
  typedef struct packed {
    logic [NTRI-1:0]        pend;
    tri_edges_t [NTRI-1:0]  tris;
  } cube_tris_t;

  typedef struct packed {
    logic [ID_W-1:0] base;
    cube_tris_t      cube;
  } tct_load_t;

  function automatic logic [EDGE_W-1:0] local_edge(input logic [2:0] p, input logic [2:0] q);
    logic [EDGE_W-1:0] r;
    r = '0;
    for (int i = NUM_EDGES - 1; i >= 0; i--) begin
      if ((EDGE_ENDS[i][0] == p && EDGE_ENDS[i][1] == q) ||
          (EDGE_ENDS[i][0] == q && EDGE_ENDS[i][1] == p)) begin
        r = EDGE_W'(i);
      end
    end
    return r;
  endfunction

  function automatic cube_tris_t build_cube(input logic [7:0] above, input logic in_range);
    cube_tris_t r;
    logic [3:0] m;
    logic [2:0] v [4];
    logic [1:0] kind;
    r = '0;
    for (int t = 0; t < NUM_TETRA; t++) begin
      m = '0;
      for (int k = 0; k < 4; k++) begin
        m[k] = above[TETRA[t][k]];
      end
      for (int i = 0; i < 4; i++) begin
        v[i] = TETRA[t][MASK_PERM[m][i]];
      end
      kind = in_range ? MASK_KIND[m] : KIND_NONE;
      case (kind)
        KIND_ONE: begin
          r.pend[2*t]   = 1'b1;
          r.tris[2*t].a = local_edge(v[0], v[1]);
          r.tris[2*t].b = local_edge(v[0], v[2]);
          r.tris[2*t].c = local_edge(v[0], v[3]);
        end
        KIND_TWO: begin
          r.pend[2*t]     = 1'b1;
          r.pend[2*t+1]   = 1'b1;
          r.tris[2*t].a   = local_edge(v[0], v[2]);
          r.tris[2*t].b   = local_edge(v[0], v[3]);
          r.tris[2*t].c   = local_edge(v[1], v[2]);
          r.tris[2*t+1].a = local_edge(v[1], v[2]);
          r.tris[2*t+1].b = local_edge(v[0], v[3]);
          r.tris[2*t+1].c = local_edge(v[1], v[3]);
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/tct_cube_if.sv -----
`timescale 1ns / 1ps
// tct_cube_if: valid/ready channel carrying one grid cube (position and corner samples)
// depends on tct_pkg for field widths
interface tct_cube_if;
  import tct_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [COORD_W-1:0]  cube_x;
  logic        [COORD_W-1:0]  cube_y;
  logic        [COORD_W-1:0]  cube_z;
  logic signed [SAMPLE_W-1:0] sample_c0;
  logic signed [SAMPLE_W-1:0] sample_c1;
  logic signed [SAMPLE_W-1:0] sample_c2;
  logic signed [SAMPLE_W-1:0] sample_c3;
  logic signed [SAMPLE_W-1:0] sample_c4;
  logic signed [SAMPLE_W-1:0] sample_c5;
  logic signed [SAMPLE_W-1:0] sample_c6;
  logic signed [SAMPLE_W-1:0] sample_c7;

  modport source (
    output valid, cube_x, cube_y, cube_z,
    output sample_c0, sample_c1, sample_c2, sample_c3,
    output sample_c4, sample_c5, sample_c6, sample_c7,
    input  ready
  );

  modport sink (
    input  valid, cube_x, cube_y, cube_z,
    input  sample_c0, sample_c1, sample_c2, sample_c3,
    input  sample_c4, sample_c5, sample_c6, sample_c7,
    output ready
  );
endinterface

// ----- rtl/tct_tri_if.sv -----
`timescale 1ns / 1ps
// tct_tri_if: valid/ready channel carrying one triangle as three global edge ids
// depends on tct_pkg for field widths
interface tct_tri_if;
  import tct_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] tri_edge_a;
  logic [ID_W-1:0] tri_edge_b;
  logic [ID_W-1:0] tri_edge_c;
  logic            last;

  modport source (output valid, tri_edge_a, tri_edge_b, tri_edge_c, last, input ready);
  modport sink   (input valid, tri_edge_a, tri_edge_b, tri_edge_c, last, output ready);
endinterface

// ----- rtl/tct_emitter.sv -----
`timescale 1ns / 1ps
// tct_emitter: holds one cube's triangle slots and sends them out one per cycle unless stalled
// depends on tct_pkg and tct_tri_if
module tct_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld_valid,
  output logic               ld_ready,
  input  tct_pkg::tct_load_t ld_data,
  tct_tri_if.source          out_tri
);
  import tct_pkg::*;

  logic [NTRI-1:0]       pend_r;
  logic [NTRI-1:0]       pend_clr;
  tri_edges_t [NTRI-1:0] tris_r;
  logic [ID_W-1:0]       base_r;
  logic [SEL_W-1:0]      sel;
  tri_edges_t            cur;
  logic                  busy;
  logic                  o_load;

  logic                  o_v_r;
  logic [ID_W-1:0]       o_a_r;
  logic [ID_W-1:0]       o_b_r;
  logic [ID_W-1:0]       o_c_r;
  logic                  o_last_r;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = NTRI - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign cur      = tris_r[sel];
  assign pend_clr = pend_r & (pend_r - NTRI'(1));
  assign busy     = |pend_r;
  assign o_load   = busy && (!o_v_r || out_tri.ready);
  assign ld_ready = !busy || (o_load && (pend_clr == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (ld_valid && ld_ready) begin
      pend_r <= ld_data.cube.pend;
    end else if (o_load) begin
      pend_r <= pend_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      tris_r <= ld_data.cube.tris;
      base_r <= ld_data.base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_load) begin
      o_v_r <= 1'b1;
    end else if (out_tri.ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_a_r    <= base_r + {{(ID_W-EDGE_W){1'b0}}, cur.a};
      o_b_r    <= base_r + {{(ID_W-EDGE_W){1'b0}}, cur.b};
      o_c_r    <= base_r + {{(ID_W-EDGE_W){1'b0}}, cur.c};
      o_last_r <= (pend_clr == '0);
    end
  end

  assign out_tri.valid      = o_v_r;
  assign out_tri.tri_edge_a = o_a_r;
  assign out_tri.tri_edge_b = o_b_r;
  assign out_tri.tri_edge_c = o_c_r;
  assign out_tri.last       = o_last_r;

endmodule

// ----- rtl/tetra_cube_triangulator.sv -----
`timescale 1ns / 1ps
// tetra_cube_triangulator: six-tetrahedron marching-tetrahedra triangulator, top level
// depends on tct_pkg, tct_cube_if, tct_tri_if and tct_emitter
//
//   channel   | dir | handshake            | transaction
//   ----------+-----+----------------------+----------------------------------------
//   in_cube   | in  | valid/ready          | one cube: x, y, z and eight corner samples
//   out_tri   | out | valid/ready          | one triangle: edge ids a, b and c, and last flag
//   cfg       | in  | cfg_we, no ready     | grid_div write, taken at once
//
// the emitter sends one triangle per cycle unless out_tri stalls, so a cube with n triangles
// (n up to 12) keeps it busy until its last one loads; cubes with no triangles are dropped at entry
// first triangle passes stages a, b and c, the emitter slots and its output register to reach out_tri
// reset is synchronous: clears all valid bits and sets grid_div to 64, or to the cap if MAX_DIV is lower
// a stall on out_tri backs up through the stages; every stage refills the cycle it frees
module tetra_cube_triangulator #(
  parameter int unsigned MAX_DIV = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [tct_pkg::DIV_W-1:0] cfg_wdata,
  tct_cube_if.sink                  in_cube,
  tct_tri_if.source                 out_tri
);
  import tct_pkg::*;

  // grid_div above the cap acts as the cap
  localparam logic [DIV_W-1:0] DIV_CAP = (MAX_DIV > 127) ? 7'd127 : DIV_W'(MAX_DIV);

  logic [DIV_W-1:0] div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= (RESET_DIV > DIV_CAP) ? DIV_CAP : RESET_DIV;
    end else if (cfg_we) begin
      div_r <= (cfg_wdata > DIV_CAP) ? DIV_CAP : cfg_wdata;
    end
  end

  // entry: sign tests, range check and triangle table lookup
  logic [7:0]  above;
  logic        in_range;
  logic        in_acc;
  cube_tris_t  cube_in;

  assign above[0] = !in_cube.sample_c0[SAMPLE_W-1] && (in_cube.sample_c0 != '0);
  assign above[1] = !in_cube.sample_c1[SAMPLE_W-1] && (in_cube.sample_c1 != '0);
  assign above[2] = !in_cube.sample_c2[SAMPLE_W-1] && (in_cube.sample_c2 != '0);
  assign above[3] = !in_cube.sample_c3[SAMPLE_W-1] && (in_cube.sample_c3 != '0);
  assign above[4] = !in_cube.sample_c4[SAMPLE_W-1] && (in_cube.sample_c4 != '0);
  assign above[5] = !in_cube.sample_c5[SAMPLE_W-1] && (in_cube.sample_c5 != '0);
  assign above[6] = !in_cube.sample_c6[SAMPLE_W-1] && (in_cube.sample_c6 != '0);
  assign above[7] = !in_cube.sample_c7[SAMPLE_W-1] && (in_cube.sample_c7 != '0);

  assign in_range = ({1'b0, in_cube.cube_x} < div_r) &&
                    ({1'b0, in_cube.cube_y} < div_r) &&
                    ({1'b0, in_cube.cube_z} < div_r);

  assign cube_in = build_cube(above, in_range);
  assign in_acc  = in_cube.valid && in_cube.ready;

  // stage a: coordinates and triangle slots
  logic               a_v_r;
  logic [COORD_W-1:0] a_x_r;
  logic [COORD_W-1:0] a_y_r;
  logic [COORD_W-1:0] a_z_r;
  cube_tris_t         a_cube_r;

  // stage b: z*div + y
  logic               b_v_r;
  logic [ZY_W-1:0]    b_zy_r;
  logic [COORD_W-1:0] b_x_r;
  cube_tris_t         b_cube_r;
  logic [ZY_W-1:0]    zy_c;

  // stage c: cube index
  logic               c_v_r;
  logic [IDX_W-1:0]   c_idx_r;
  cube_tris_t         c_cube_r;
  logic [IDX_W-1:0]   idx_c;

  logic               a_ready;
  logic               b_ready;
  logic               c_ready;
  logic               ld_ready;
  logic [IDX_W+4:0]   idx19;
  tct_load_t          ld_data;

  assign c_ready       = !c_v_r || ld_ready;
  assign b_ready       = !b_v_r || c_ready;
  assign a_ready       = !a_v_r || b_ready;
  assign in_cube.ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      // a cube with no triangle never enters the pipe
      if (a_ready) begin
        a_v_r <= in_acc && (|cube_in.pend);
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
      if (c_ready) begin
        c_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_acc) begin
      a_x_r    <= in_cube.cube_x;
      a_y_r    <= in_cube.cube_y;
      a_z_r    <= in_cube.cube_z;
      a_cube_r <= cube_in;
    end
  end

  assign zy_c = ZY_W'(a_z_r) * ZY_W'(div_r) + ZY_W'(a_y_r);

  always_ff @(posedge clk) begin
    if (b_ready && a_v_r) begin
      b_zy_r   <= zy_c;
      b_x_r    <= a_x_r;
      b_cube_r <= a_cube_r;
    end
  end

  assign idx_c = IDX_W'(b_zy_r) * IDX_W'(div_r) + IDX_W'(b_x_r);

  always_ff @(posedge clk) begin
    if (c_ready && b_v_r) begin
      c_idx_r  <= idx_c;
      c_cube_r <= b_cube_r;
    end
  end

  // index * 19 as shift-add, kept modulo 2^23
  assign idx19 = {c_idx_r, 4'b0000} + {3'b000, c_idx_r, 1'b0} + {5'b00000, c_idx_r};

  assign ld_data.base = idx19[ID_W-1:0];
  assign ld_data.cube = c_cube_r;

  tct_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (c_v_r),
    .ld_ready (ld_ready),
    .ld_data  (ld_data),
    .out_tri  (out_tri)
  );

endmodule

// ----- rtl/tct_checker.sv -----
`timescale 1ns / 1ps
// tct_checker: port-level assertions for tetra_cube_triangulator, attached by bind
// depends on tct_pkg for widths
module tct_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [tct_pkg::ID_W-1:0] out_a,
  input logic [tct_pkg::ID_W-1:0] out_b,
  input logic [tct_pkg::ID_W-1:0] out_c,
  input logic                     out_last
);

  // a stalled triangle stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b) &&
    $stable(out_c) && $stable(out_last))
    else $error("stalled triangle changed");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("triangle valid after reset");

  // the three vertices of a triangle lie on different edges of one cube
  a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_a != out_b) && (out_b != out_c) && (out_a != out_c))
    else $error("degenerate triangle");

endmodule

bind tetra_cube_triangulator tct_checker u_tct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_tri.valid),
  .out_ready (out_tri.ready),
  .out_a     (out_tri.tri_edge_a),
  .out_b     (out_tri.tri_edge_b),
  .out_c     (out_tri.tri_edge_c),
  .out_last  (out_tri.last)
);

// ----- bench/tetra_cube_triangulator_test.sv -----
`timescale 1ns / 1ps
// tetra_cube_triangulator_test: self-checking bench for the six-tetrahedron cube triangulator
// depends on tct_pkg, tct_cube_if, tct_tri_if and tetra_cube_triangulator from the rtl folder
package tct_bench_pkg;
  import tct_pkg::*;

  localparam int unsigned GRID_MAX = 64;
  localparam int unsigned EDGES_PER_CUBE = 19;

  typedef enum logic [1:0] {NO_TRI, ONE_TRI, TWO_TRI} tri_count_e;

  // corners of each tetrahedron, all share the 0 to 7 diagonal
  localparam logic [0:5][0:3][2:0] TETRA_CORNERS = {
    3'd0, 3'd1, 3'd5, 3'd7,  3'd0, 3'd5, 3'd4, 3'd7,  3'd0, 3'd4, 3'd6, 3'd7,
    3'd0, 3'd6, 3'd2, 3'd7,  3'd0, 3'd2, 3'd3, 3'd7,  3'd0, 3'd3, 3'd1, 3'd7
  };

  // vertex order per inside mask
  localparam logic [0:15][0:3][1:0] VERTEX_ORDER = {
    2'd0, 2'd1, 2'd2, 2'd3,  2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd2, 2'd0, 2'd3,  2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd3, 2'd0, 2'd1,  2'd0, 2'd2, 2'd3, 2'd1,
    2'd1, 2'd2, 2'd0, 2'd3,  2'd3, 2'd0, 2'd1, 2'd2,
    2'd3, 2'd0, 2'd2, 2'd1,  2'd3, 2'd0, 2'd2, 2'd1,
    2'd1, 2'd3, 2'd2, 2'd0,  2'd2, 2'd3, 2'd1, 2'd0,
    2'd2, 2'd3, 2'd0, 2'd1,  2'd1, 2'd2, 2'd3, 2'd0,
    2'd0, 2'd3, 2'd2, 2'd1,  2'd0, 2'd1, 2'd2, 2'd3
  };

  localparam logic [0:15][1:0] TRI_COUNT = {
    NO_TRI,  ONE_TRI, ONE_TRI, TWO_TRI, ONE_TRI, TWO_TRI, TWO_TRI, ONE_TRI,
    ONE_TRI, TWO_TRI, TWO_TRI, ONE_TRI, TWO_TRI, ONE_TRI, ONE_TRI, NO_TRI
  };

  typedef struct packed {
    logic [COORD_W-1:0]            x;
    logic [COORD_W-1:0]            y;
    logic [COORD_W-1:0]            z;
    logic [7:0][SAMPLE_W-1:0]      sample;
  } cube_t;

  typedef struct packed {
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic [ID_W-1:0] c;
    logic            last;
  } tri_t;

  function automatic int unsigned clamp_div(logic [DIV_W-1:0] div);
    return (div > GRID_MAX) ? GRID_MAX : int'(div);
  endfunction

  function automatic bit cube_in_grid(cube_t c, logic [DIV_W-1:0] div);
    int unsigned lim;
    lim = clamp_div(div);
    return (c.x < lim) && (c.y < lim) && (c.z < lim);
  endfunction

  // local edge number joining two cube corners, looked up by the sorted pair
  function automatic int unsigned edge_num(logic [2:0] p, logic [2:0] q);
    logic [2:0] lo;
    logic [2:0] hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    case ({lo, hi})
      6'o01: return 0;
      6'o13: return 1;
      6'o23: return 2;
      6'o02: return 3;
      6'o45: return 4;
      6'o57: return 5;
      6'o67: return 6;
      6'o46: return 7;
      6'o04: return 8;
      6'o15: return 9;
      6'o26: return 10;
      6'o37: return 11;
      6'o03: return 12;
      6'o06: return 13;
      6'o05: return 14;
      6'o47: return 15;
      6'o17: return 16;
      6'o27: return 17;
      6'o07: return 18;
      default: return 0;
    endcase
  endfunction

  class cube_tri_board;
    tri_t            pending_tris[$];
    logic [DIV_W-1:0] grid_div;
    int              errors;

    function new();
      grid_div = RESET_DIV;
      errors = 0;
    endfunction

    function void set_div(logic [DIV_W-1:0] div);
      grid_div = div;
    endfunction

    function void add_tri(int unsigned base, int unsigned ea, int unsigned eb,
                          int unsigned ec);
      tri_t t;
      t.a = ID_W'(base + ea);
      t.b = ID_W'(base + eb);
      t.c = ID_W'(base + ec);
      t.last = 1'b0;
      pending_tris.push_back(t);
    endfunction

    // triangles that one accepted cube must produce, in output order
    function void note_cube(cube_t c);
      int unsigned lim;
      int unsigned base;
      int          n;
      logic [7:0]  above;
      logic [3:0]  m;
      logic [2:0]  v [4];
      tri_count_e  kind;
      n = 0;
      if (!cube_in_grid(c, grid_div)) return;
      lim = clamp_div(grid_div);
      for (int k = 0; k < 8; k++) above[k] = $signed(c.sample[k]) > 0;
      base = ((int'(c.z) * lim + int'(c.y)) * lim + int'(c.x)) * EDGES_PER_CUBE;
      for (int t = 0; t < 6; t++) begin
        for (int k = 0; k < 4; k++) m[k] = above[TETRA_CORNERS[t][k]];
        for (int i = 0; i < 4; i++) v[i] = TETRA_CORNERS[t][VERTEX_ORDER[m][i]];
        kind = tri_count_e'(TRI_COUNT[m]);
        case (kind)
          ONE_TRI: begin
            add_tri(base, edge_num(v[0], v[1]), edge_num(v[0], v[2]), edge_num(v[0], v[3]));
            n++;
          end
          TWO_TRI: begin
            add_tri(base, edge_num(v[0], v[2]), edge_num(v[0], v[3]), edge_num(v[1], v[2]));
            add_tri(base, edge_num(v[1], v[2]), edge_num(v[0], v[3]), edge_num(v[1], v[3]));
            n += 2;
          end
          default: begin
          end
        endcase
      end
      if (n > 0) pending_tris[pending_tris.size()-1].last = 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] triangle check failed: %s", $time, msg);
      errors++;
    endtask

    task check_tri(tri_t got);
      tri_t want;
      if (pending_tris.size() == 0) begin
        report_mismatch($sformatf("unexpected triangle %0d %0d %0d last %0b",
                                  got.a, got.b, got.c, got.last));
        return;
      end
      want = pending_tris.pop_front();
      if (got.a !== want.a)
        report_mismatch($sformatf("edge a got %0d want %0d", got.a, want.a));
      if (got.b !== want.b)
        report_mismatch($sformatf("edge b got %0d want %0d", got.b, want.b));
      if (got.c !== want.c)
        report_mismatch($sformatf("edge c got %0d want %0d", got.c, want.c));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

endpackage

module tetra_cube_triangulator_test;
  import tct_pkg::*;
  import tct_bench_pkg::*;

  // a worst-case run of ~150 cubes with 12 triangles each under the longest stalls stays far below this
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 20;

  // directed inside patterns: empty, full, each single corner, the shared diagonal
  // (12 triangles), its complement and a few mixed ones
  localparam logic [0:17][7:0] DIRECTED_MASKS = {
    8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
    8'h80, 8'h81, 8'h7E, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h3C, 8'hC3
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [DIV_W-1:0] cfg_wdata;

  tct_cube_if cube_ch ();
  tct_tri_if  tri_ch ();

  cube_tri_board sb;

  bit tx_idle_on;
  bit rx_idle_on;
  int hold_reqs;
  int unsigned cycles;

  tetra_cube_triangulator #(
    .MAX_DIV (GRID_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cube   (cube_ch),
    .out_tri   (tri_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // one corner sample: positive when above zero, zero or negative otherwise
  function automatic logic [SAMPLE_W-1:0] pick_sample(bit above);
    if (above) begin
      case ($urandom_range(0, 3))
        0:       return 16'h0001;
        1:       return 16'h7FFF;
        default: return SAMPLE_W'($urandom_range(1, 32767));
      endcase
    end else begin
      case ($urandom_range(0, 4))
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        2:       return 16'h8000;
        default: return {1'b1, 15'($urandom)};
      endcase
    end
  endfunction

  function automatic cube_t shape_cube(logic [7:0] inside_mask);
    cube_t c;
    c.x = COORD_W'($urandom);
    c.y = COORD_W'($urandom);
    c.z = COORD_W'($urandom);
    for (int k = 0; k < 8; k++) c.sample[k] = pick_sample(inside_mask[k]);
    return c;
  endfunction

  // random cube for a grid setting; a tenth of them land anywhere, so some fall outside
  function automatic cube_t random_cube(logic [DIV_W-1:0] div);
    cube_t       c;
    int unsigned lim;
    logic [7:0]  pat;
    lim = clamp_div(div);
    case ($urandom_range(0, 7))
      0:       pat = 8'h00;
      1:       pat = 8'hFF;
      default: pat = 8'($urandom);
    endcase
    c = shape_cube(pat);
    if (lim > 0 && $urandom_range(0, 9) != 0) begin
      c.x = COORD_W'($urandom_range(0, lim - 1));
      c.y = COORD_W'($urandom_range(0, lim - 1));
      c.z = COORD_W'($urandom_range(0, lim - 1));
    end
    return c;
  endfunction

  // present one cube and hold it until the transaction completes
  task send_cube(cube_t c);
    cube_ch.cube_x    <= c.x;
    cube_ch.cube_y    <= c.y;
    cube_ch.cube_z    <= c.z;
    cube_ch.sample_c0 <= c.sample[0];
    cube_ch.sample_c1 <= c.sample[1];
    cube_ch.sample_c2 <= c.sample[2];
    cube_ch.sample_c3 <= c.sample[3];
    cube_ch.sample_c4 <= c.sample[4];
    cube_ch.sample_c5 <= c.sample[5];
    cube_ch.sample_c6 <= c.sample[6];
    cube_ch.sample_c7 <= c.sample[7];
    cube_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cube_ch.ready);
    sb.note_cube(c);
    // optional gap; valid stays up otherwise so back-to-back transactions are possible
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      cube_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // sender pauses until every triangle is back, then lets the pipe settle
  // (out-of-range cubes produce nothing and are dropped at entry)
  task wait_drained();
    cube_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_tris.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // grid_div write, only issued while drained
  task write_div(logic [DIV_W-1:0] div);
    cfg_wdata <= div;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_div(div);
  endtask

  task run_directed();
    cube_t c;
    for (int i = 0; i < 18; i++) begin
      c = shape_cube(DIRECTED_MASKS[i]);
      case (i % 3)
        0: begin
          c.x = '0;
          c.y = '0;
          c.z = '0;
        end
        1: begin
          c.x = '1;
          c.y = '1;
          c.z = '1;
        end
        default: begin
        end
      endcase
      send_cube(c);
    end
    // sample extremes side by side, zero counts as outside
    c.x = 6'd63;
    c.y = 6'd0;
    c.z = 6'd63;
    c.sample = {16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001};
    send_cube(c);
  endtask

  // random phases, each under its own grid setting and idling mix
  task run_random();
    cube_t            c;
    logic [DIV_W-1:0] div;
    int               target;
    int               counted;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       div = 7'd64;
        1:       div = 7'd127;
        2:       div = 7'd9;
        3:       div = 7'd1;
        4:       div = 7'd0;
        5:       div = 7'd65;
        6:       div = 7'd2;
        default: div = DIV_W'($urandom_range(3, 63));
      endcase
      write_div(div);
      tx_idle_on = (ph % 3) != 1;
      rx_idle_on = (ph % 3) != 2;
      // long receiver hold-off while the sender keeps pushing: fills the pipe
      if (ph == 0) begin
        tx_idle_on = 1'b0;
        hold_reqs++;
      end
      // with zero divisions every cube is dropped, so keep that phase short
      target = (div == 0) ? 6 : 17;
      counted = 0;
      while (counted < target) begin
        c = random_cube(div);
        send_cube(c);
        if (div == 0 || cube_in_grid(c, div)) counted++;
        // mid-phase pause without a register write
        if (ph == 2 && counted == target / 2) wait_drained();
      end
      wait_drained();
    end
  endtask

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    int hold_left;
    int stall_left;
    int hold_taken;
    hold_left = 0;
    stall_left = 0;
    hold_taken = 0;
    tri_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_taken) begin
        hold_taken = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        tri_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        tri_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        tri_ch.ready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        tri_ch.ready <= 1'b1;
      end
    end
  end

  // every completed result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n === 1'b1 && tri_ch.valid === 1'b1 && tri_ch.ready === 1'b1) begin
      sb.check_tri({tri_ch.tri_edge_a, tri_ch.tri_edge_b, tri_ch.tri_edge_c, tri_ch.last});
    end
  end

  initial begin
    sb = new();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_reqs = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    cube_ch.valid <= 1'b0;
    cube_ch.cube_x <= '0;
    cube_ch.cube_y <= '0;
    cube_ch.cube_z <= '0;
    cube_ch.sample_c0 <= '0;
    cube_ch.sample_c1 <= '0;
    cube_ch.sample_c2 <= '0;
    cube_ch.sample_c3 <= '0;
    cube_ch.sample_c4 <= '0;
    cube_ch.sample_c5 <= '0;
    cube_ch.sample_c6 <= '0;
    cube_ch.sample_c7 <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs on the reset value of grid_div
    run_directed();
    wait_drained();

    run_random();

    // put the register back to its reset value at the end
    write_div(RESET_DIV);
    wait_drained();

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
